/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the calibrator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication after a fixed number of cycles, disabled while reset is high.
`define ASSERT_DELAYED(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("delayed check failed");

`endif

/* design/psc_pkg.sv */
// ---------------------------------------------------------------------------
// Platt sigmoid calibrator package
// Widths, stage counts, flag bundle and constant tables shared by the RTL.
// ---------------------------------------------------------------------------
package psc_pkg;

  // Field and datapath widths.
  localparam int unsigned MARGIN_W    = 24;  // signed Q8.16
  localparam int unsigned PROB_W      = 16;  // unsigned Q0.16
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned U_W         = 20;  // |x| below the 16.0 cutoff, Q.16
  localparam int unsigned Q32_W       = 32;
  localparam int unsigned R_W         = U_W + 8;        // u/256 in Q0.32
  localparam int unsigned TERM_W      = R_W;
  localparam int unsigned P_W         = 2 * R_W - Q32_W; // term*r >> 32
  localparam int unsigned SUM_W       = Q32_W + 1;
  localparam int unsigned DEN_W       = Q32_W + 1;
  localparam int unsigned NUM_W       = 50;
  localparam int unsigned QUO_W       = 17;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 24;

  // Series and squaring counts.
  localparam int unsigned SERIES_FIRST = 2;
  localparam int unsigned SERIES_LAST  = 6;
  localparam int unsigned SQUARINGS    = 8;

  // Pipeline depth of each section.
  localparam int unsigned AFF_STAGES = 3;
  localparam int unsigned EXP_STAGES = 2 * (SERIES_LAST - SERIES_FIRST + 1) + 1 + SQUARINGS;
  localparam int unsigned DIV_STEPS  = (QUO_W + 1) / 2;
  localparam int unsigned DIV_STAGES = DIV_STEPS + 2;

  // Fixed-point constants.
  localparam logic [SUM_W-1:0]   ONE_Q32   = SUM_W'(1) << Q32_W;
  localparam logic [2*Q32_W-1:0] HALF_LSB  = (2 * Q32_W)'(1) << (Q32_W - 1);
  localparam logic [NUM_W-1:0]   ONE_Q48   = NUM_W'(1) << (Q32_W + FRAC_W);
  localparam logic [PROB_W-1:0]  HALF_Q16  = PROB_W'(1) << (PROB_W - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE   = 8'd0,
    REG_COEF_A = 8'd1,
    REG_COEF_B = 8'd2
  } cfg_reg_t;

  // Special-case flags that travel with each item.
  typedef struct packed {
    logic neg;   // argument below zero
    logic zero;  // argument exactly zero
    logic big;   // |argument| at or above 16.0
  } psc_flags_t;

  // floor(2^32 / k) for the series divisors.
  function automatic logic [Q32_W-1:0] recip_q32(input int unsigned k);
    logic [Q32_W-1:0] rcp;
    case (k)
      2: rcp = 32'h8000_0000;
      3: rcp = 32'h5555_5555;
      4: rcp = 32'h4000_0000;
      5: rcp = 32'h3333_3333;
      6: rcp = 32'h2AAA_AAAA;
      default: rcp = 32'hFFFF_FFFF;
    endcase
    return rcp;
  endfunction

endpackage

/* design/psc_affine.sv */
// ---------------------------------------------------------------------------
// Affine front end
// Forms the sigmoid argument (margin, or -(A*margin+B) saturated) and splits
// it into magnitude and special-case flags over three stages.
// ---------------------------------------------------------------------------
module psc_affine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [psc_pkg::MARGIN_W-1:0]   margin,
  input  logic                                  mode,
  input  logic signed [psc_pkg::MARGIN_W-1:0]   coef_a,
  input  logic signed [psc_pkg::MARGIN_W-1:0]   coef_b,
  output logic                                  out_valid,
  output logic [psc_pkg::U_W-1:0]               mag,
  output psc_pkg::psc_flags_t                   flags
);
  import psc_pkg::*;

  localparam int unsigned PROD_W = 2 * MARGIN_W;
  localparam int unsigned T_W    = PROD_W - FRAC_W + 1;
  localparam int unsigned X_W    = MARGIN_W + 1;

  logic                       v1;
  logic signed [PROD_W-1:0]   prod;
  logic signed [MARGIN_W-1:0] margin1;
  logic                       mode1;
  logic                       v2;
  logic signed [X_W-1:0]      x;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [T_W-1:0]      t_full;
  logic signed [MARGIN_W-1:0] t_sat;
  logic signed [X_W-1:0]      x_next;
  logic [X_W-1:0]             absx;

  // Stage 1: slope times margin.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= coef_a * margin;
    margin1 <= margin;
    mode1   <= mode;
  end

  // Stage 2: round half up, add the offset, saturate and negate.
  assign prod_rnd = prod + 48'sd32768;
  assign t_full   = T_W'(prod_rnd >>> FRAC_W) + T_W'(coef_b);

  always_comb begin
    if (!t_full[T_W-1] && (|t_full[T_W-2:MARGIN_W-1])) begin
      t_sat = {1'b0, {(MARGIN_W-1){1'b1}}};
    end else if (t_full[T_W-1] && !(&t_full[T_W-2:MARGIN_W-1])) begin
      t_sat = {1'b1, {(MARGIN_W-1){1'b0}}};
    end else begin
      t_sat = t_full[MARGIN_W-1:0];
    end
  end

  assign x_next = mode1 ? -X_W'(t_sat) : X_W'(margin1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
  end

  // Stage 3: magnitude and special-case flags.
  assign absx = x[X_W-1] ? -x : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    mag        <= absx[U_W-1:0];
    flags.neg  <= x[X_W-1];
    flags.zero <= (absx == '0);
    flags.big  <= |absx[X_W-1:U_W];
  end

endmodule

/* design/psc_exp.sv */
// ---------------------------------------------------------------------------
// Exponential pipeline
// exp(-u) in Q0.32: a series on u/256 up to the sixth power, one multiply stage and
// one divide-by-constant stage per term from the square up, then eight rounded squaring stages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_exp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [psc_pkg::U_W-1:0]       mag,
  input  psc_pkg::psc_flags_t           in_flags,
  output logic                          out_valid,
  output logic [psc_pkg::Q32_W-1:0]     e,
  output psc_pkg::psc_flags_t           out_flags
);
  import psc_pkg::*;

  localparam bit LAST_SUB = (SERIES_LAST % 2) == 1;

  logic [R_W-1:0] r_in;

  // Registers after each multiply stage of the series.
  logic              mv    [SERIES_FIRST:SERIES_LAST];
  logic [P_W-1:0]    mp    [SERIES_FIRST:SERIES_LAST];
  logic [SUM_W-1:0]  msum  [SERIES_FIRST:SERIES_LAST];
  logic [R_W-1:0]    mr    [SERIES_FIRST:SERIES_LAST];
  psc_flags_t        mf    [SERIES_FIRST:SERIES_LAST];

  // Registers after each divide stage of the series.
  logic              dv    [SERIES_FIRST:SERIES_LAST];
  logic [TERM_W-1:0] dterm [SERIES_FIRST:SERIES_LAST];
  logic [SUM_W-1:0]  dsum  [SERIES_FIRST:SERIES_LAST];
  logic [R_W-1:0]    dr    [SERIES_FIRST:SERIES_LAST];
  psc_flags_t        df    [SERIES_FIRST:SERIES_LAST];

  // Squaring chain; entry 0 is the closing series add.
  logic              sqv   [0:SQUARINGS];
  logic [Q32_W-1:0]  sq    [0:SQUARINGS];
  psc_flags_t        sqf   [0:SQUARINGS];

  logic [SUM_W-1:0]  fsum;

  assign r_in = {mag, {(R_W-U_W){1'b0}}};

  // Series: each term is (previous term * r) >> 32, divided by k.
  for (genvar k = SERIES_FIRST; k <= SERIES_LAST; k++) begin : g_series
    localparam bit SUB = ((k - 1) % 2) == 1;
    localparam logic [Q32_W-1:0] RCP = recip_q32(k);

    logic              in_v;
    logic [TERM_W-1:0] in_term;
    logic [SUM_W-1:0]  in_sum;
    logic [R_W-1:0]    in_r;
    psc_flags_t        in_f;
    logic [2*R_W-1:0]  prod;
    logic [SUM_W-1:0]  sum_upd;
    logic [P_W+Q32_W-1:0] qprod;
    logic [P_W-1:0]    q0;
    logic [P_W-1:0]    rem0;
    logic [P_W-1:0]    term_k;

    if (k == SERIES_FIRST) begin : g_head
      // First term is r itself; the sum starts at one.
      assign in_v    = in_valid;
      assign in_term = r_in;
      assign in_sum  = ONE_Q32;
      assign in_r    = r_in;
      assign in_f    = in_flags;
    end else begin : g_link
      assign in_v    = dv[k-1];
      assign in_term = dterm[k-1];
      assign in_sum  = dsum[k-1];
      assign in_r    = dr[k-1];
      assign in_f    = df[k-1];
    end

    // Multiply stage; the previous term is folded into the sum here.
    assign prod    = in_term * in_r;
    assign sum_upd = SUB ? in_sum - SUM_W'(in_term) : in_sum + SUM_W'(in_term);

    always_ff @(posedge clk) begin
      if (rst) begin
        mv[k] <= 1'b0;
      end else begin
        mv[k] <= in_v;
      end
    end

    always_ff @(posedge clk) begin
      mp[k]   <= prod[2*R_W-1:Q32_W];
      msum[k] <= sum_upd;
      mr[k]   <= in_r;
      mf[k]   <= in_f;
    end

    // Divide stage: reciprocal estimate is exact or one low, then fixed up.
    assign qprod  = mp[k] * RCP;
    assign q0     = qprod[P_W+Q32_W-1:Q32_W];
    assign rem0   = mp[k] - q0 * P_W'(k);
    assign term_k = (rem0 >= P_W'(k)) ? q0 + P_W'(1) : q0;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else begin
        dv[k] <= mv[k];
      end
    end

    always_ff @(posedge clk) begin
      dterm[k] <= TERM_W'(term_k);
      dsum[k]  <= msum[k];
      dr[k]    <= mr[k];
      df[k]    <= mf[k];
    end
  end

  // Closing stage: fold in the last term.
  assign fsum = LAST_SUB ? dsum[SERIES_LAST] - SUM_W'(dterm[SERIES_LAST])
                         : dsum[SERIES_LAST] + SUM_W'(dterm[SERIES_LAST]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else begin
      sqv[0] <= dv[SERIES_LAST];
    end
  end

  always_ff @(posedge clk) begin
    sq[0]  <= fsum[Q32_W-1:0];
    sqf[0] <= df[SERIES_LAST];
  end

  // Squarings: e = (e*e + 2^31) >> 32, one per stage.
  for (genvar j = 0; j < SQUARINGS; j++) begin : g_square
    logic [2*Q32_W-1:0] sqprod;

    assign sqprod = sq[j] * sq[j] + HALF_LSB;

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[j+1] <= 1'b0;
      end else begin
        sqv[j+1] <= sqv[j];
      end
    end

    always_ff @(posedge clk) begin
      sq[j+1]  <= sqprod[2*Q32_W-1:Q32_W];
      sqf[j+1] <= sqf[j];
    end
  end

  assign out_valid = sqv[SQUARINGS];
  assign e         = sq[SQUARINGS];
  assign out_flags = sqf[SQUARINGS];

  // Squaring a Q0.32 value below one never makes it grow.
  `ASSERT_IMPLIES(a_square_no_growth, clk, rst, sqv[SQUARINGS], sq[SQUARINGS] <= $past(sq[0], SQUARINGS))

endmodule

/* design/psc_div.sv */
// ---------------------------------------------------------------------------
// Probability divider
// Rounded quotient 2^48/(2^32+e) or e*2^16/(2^32+e) by pipelined restoring
// division, two quotient bits per stage and one in the last, then special cases and saturation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [psc_pkg::Q32_W-1:0]     e,
  input  psc_pkg::psc_flags_t           in_flags,
  output logic                          done,
  output logic [psc_pkg::PROB_W-1:0]    probability
);
  import psc_pkg::*;

  logic [DEN_W-1:0]  den_in;
  logic [NUM_W-1:0]  num_in;
  logic [PROB_W-1:0] prob_next;

  // Division pipeline registers; entry 0 is the setup stage.
  logic              rv   [0:DIV_STEPS];
  logic [NUM_W-1:0]  rrem [0:DIV_STEPS];
  logic [DEN_W-1:0]  rden [0:DIV_STEPS];
  logic [QUO_W-1:0]  rq   [0:DIV_STEPS];
  psc_flags_t        rf   [0:DIV_STEPS];

  // Setup: denominator and rounded numerator.
  assign den_in = {1'b1, e};
  assign num_in = in_flags.neg ? (NUM_W'(e) << FRAC_W) + NUM_W'(den_in >> 1)
                               : ONE_Q48 + NUM_W'(den_in >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rrem[0] <= num_in;
    rden[0] <= den_in;
    rq[0]   <= '0;
    rf[0]   <= in_flags;
  end

  // Restoring steps, most significant quotient bits first.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int HI = QUO_W - 1 - 2 * j;
    localparam int LO = HI - 1;

    logic [NUM_W-1:0] dsh_hi;
    logic             bit_hi;
    logic [NUM_W-1:0] rem_a;
    logic [NUM_W-1:0] rem_b;
    logic [QUO_W-1:0] q_upd;

    assign dsh_hi = NUM_W'(rden[j]) << HI;
    assign bit_hi = rrem[j] >= dsh_hi;
    assign rem_a  = bit_hi ? rrem[j] - dsh_hi : rrem[j];

    if (LO >= 0) begin : g_two
      logic [NUM_W-1:0] dsh_lo;
      logic             bit_lo;

      assign dsh_lo = NUM_W'(rden[j]) << LO;
      assign bit_lo = rem_a >= dsh_lo;
      assign rem_b  = bit_lo ? rem_a - dsh_lo : rem_a;
      assign q_upd  = rq[j] | (QUO_W'(bit_hi) << HI) | (QUO_W'(bit_lo) << LO);
    end else begin : g_one
      assign rem_b  = rem_a;
      assign q_upd  = rq[j] | (QUO_W'(bit_hi) << HI);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[j+1] <= 1'b0;
      end else begin
        rv[j+1] <= rv[j];
      end
    end

    always_ff @(posedge clk) begin
      rrem[j+1] <= rem_b;
      rden[j+1] <= rden[j];
      rq[j+1]   <= q_upd;
      rf[j+1]   <= rf[j];
    end
  end

  // Output: large and zero arguments bypass the quotient; saturate at full scale.
  always_comb begin
    if (rf[DIV_STEPS].big) begin
      prob_next = rf[DIV_STEPS].neg ? '0 : '1;
    end else if (rf[DIV_STEPS].zero) begin
      prob_next = HALF_Q16;
    end else if (|rq[DIV_STEPS][QUO_W-1:PROB_W]) begin
      prob_next = '1;
    end else begin
      prob_next = rq[DIV_STEPS][PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    probability <= prob_next;
  end

  // After the last step the remainder must lie below the denominator.
  `ASSERT_IMPLIES(a_div_rem_below_den, clk, rst, rv[DIV_STEPS], rrem[DIV_STEPS] < NUM_W'(rden[DIV_STEPS]))

endmodule

/* design/platt_sigmoid_calibrator_core.sv */
// ---------------------------------------------------------------------------
// Platt sigmoid calibrator core
// Maps a signed Q8.16 margin to a Q0.16 probability, either sigmoid(margin)
// or 1/(1+exp(A*margin+B)) with A and B held in configuration registers.
//
// Input: a beat is taken on each clock edge with start high and busy low.
// busy is high during reset and is cleared by the first clock edge after it, then stays low,
// so one margin per cycle.
// Output: done pulses for one cycle with probability valid in that cycle, and
// results leave in input order.
// The depth is set by the exponential: five series terms at two stages each,
// a closing add and eight squarings, plus three affine stages and eleven
// divider stages (a setup stage, eight steps of two quotient bits, one step
// of one bit and the output register).
// The receiver cannot stall, so no result is ever held back.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 mode, 1 coef_a, 2 coef_b, others ignored); write only while idle.
// Reset clears the registers to zero (identity mode) and empties the pipeline.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module platt_sigmoid_calibrator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [psc_pkg::MARGIN_W-1:0]   margin,
  output logic                                  done,
  output logic [psc_pkg::PROB_W-1:0]            probability,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import psc_pkg::*;

  localparam int unsigned LATENCY = AFF_STAGES + EXP_STAGES + DIV_STAGES;

  logic                       mode;
  logic signed [MARGIN_W-1:0] coef_a;
  logic signed [MARGIN_W-1:0] coef_b;
  logic                       accept;
  logic                       aff_valid;
  logic [U_W-1:0]             aff_mag;
  psc_flags_t                 aff_flags;
  logic                       exp_valid;
  logic [Q32_W-1:0]           exp_e;
  psc_flags_t                 exp_flags;

  // Input handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      coef_a <= '0;
      coef_b <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODE) begin
        mode <= cfg_data[0];
      end
      if (cfg_index == REG_COEF_A) begin
        coef_a <= cfg_data[MARGIN_W-1:0];
      end
      if (cfg_index == REG_COEF_B) begin
        coef_b <= cfg_data[MARGIN_W-1:0];
      end
    end
  end

  // Affine front end.
  psc_affine u_affine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .margin    (margin),
    .mode      (mode),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .out_valid (aff_valid),
    .mag       (aff_mag),
    .flags     (aff_flags)
  );

  // Exponential series and squarings.
  psc_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (aff_valid),
    .mag       (aff_mag),
    .in_flags  (aff_flags),
    .out_valid (exp_valid),
    .e         (exp_e),
    .out_flags (exp_flags)
  );

  // Divider and output register.
  psc_div u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (exp_valid),
    .e           (exp_e),
    .in_flags    (exp_flags),
    .done        (done),
    .probability (probability)
  );

  // Every accepted beat yields exactly one result at the fixed latency.
  `ASSERT_DELAYED(a_result_follows_input, clk, rst, accept, LATENCY, done)
  `ASSERT_IMPLIES(a_result_has_input, clk, rst, done, $past(accept, LATENCY))

endmodule
